>>> sv/cdpc_pkg.sv
// shared widths, types and saturation helper for the complex dot product block
`timescale 1ns / 1ps

package cdpc_pkg;

    // element part width (signed Q1.15)
    localparam int PART_W = 16;
    // one partial product width (Q2.30)
    localparam int PROD_W = 2 * PART_W;
    // a sum or difference of two partial products
    localparam int TERM_W = PROD_W + 1;
    // accumulator width
    localparam int ACC_W  = 43;

    // stream widths
    localparam int IN_DATA_W  = 4 * PART_W;
    localparam int OUT_BITS   = 2 * ACC_W + 3;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // products and element flags of one item, handed to the accumulate stage
    typedef struct packed {
        logic signed [PROD_W-1:0] rr;   // u_re * v_re
        logic signed [PROD_W-1:0] ii;   // u_im * v_im
        logic signed [PROD_W-1:0] ri;   // u_re * v_im
        logic signed [PROD_W-1:0] ir;   // u_im * v_re
        logic                     eq;   // element of u equals element of v
        logic                     opp;  // element of u equals minus element of v
        logic                     last;
    } t_prod;

    // one finished result
    typedef struct packed {
        logic signed [ACC_W-1:0] dot_re;
        logic signed [ACC_W-1:0] dot_im;
        logic                    is_equal;
        logic                    is_opposite;
        logic                    is_orthogonal;
    } t_result;

    // saturating add of a term to an accumulator
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [TERM_W-1:0] term
    );
        logic signed [ACC_W:0] sum;
        begin
            sum = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - TERM_W){term[TERM_W-1]}}, term};
            if (sum[ACC_W] != sum[ACC_W-1]) begin
                // overflow: clamp towards the sign of the true sum
                sat_add = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
                sat_add = sum[ACC_W-1:0];
            end
        end
    endfunction

endpackage

>>> sv/cdpc_acc.sv
// accumulate stage: running complex sum, element flags and result forming
`timescale 1ns / 1ps

module cdpc_acc (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,       // pipeline advance
    input  logic             i_valid,    // i_item holds a live item
    input  cdpc_pkg::t_prod  i_item,
    output logic             o_res_valid,
    output cdpc_pkg::t_result o_res
);

    logic signed [cdpc_pkg::ACC_W-1:0] r_acc_re, n_acc_re;
    logic signed [cdpc_pkg::ACC_W-1:0] r_acc_im, n_acc_im;
    logic                              r_all_eq, n_all_eq;
    logic                              r_all_opp, n_all_opp;

    logic signed [cdpc_pkg::TERM_W-1:0] term_re;
    logic signed [cdpc_pkg::TERM_W-1:0] term_im;
    logic signed [cdpc_pkg::ACC_W-1:0]  acc_re_upd;
    logic signed [cdpc_pkg::ACC_W-1:0]  acc_im_upd;
    logic                               eq_upd;
    logic                               opp_upd;

    // complex product terms of this element
    assign term_re = {i_item.rr[cdpc_pkg::PROD_W-1], i_item.rr}
                   - {i_item.ii[cdpc_pkg::PROD_W-1], i_item.ii};
    assign term_im = {i_item.ri[cdpc_pkg::PROD_W-1], i_item.ri}
                   + {i_item.ir[cdpc_pkg::PROD_W-1], i_item.ir};

    // updated running state including this element
    assign acc_re_upd = cdpc_pkg::sat_add(r_acc_re, term_re);
    assign acc_im_upd = cdpc_pkg::sat_add(r_acc_im, term_im);
    assign eq_upd     = r_all_eq & i_item.eq;
    assign opp_upd    = r_all_opp & i_item.opp;

    // result from the updated state on the last element
    assign o_res_valid         = i_valid & i_item.last;
    assign o_res.dot_re        = acc_re_upd;
    assign o_res.dot_im        = acc_im_upd;
    assign o_res.is_equal      = eq_upd;
    assign o_res.is_opposite   = opp_upd;
    assign o_res.is_orthogonal = (acc_re_upd == '0) && (acc_im_upd == '0);

    // next state: hold, accumulate, or clear after the last element
    always_comb begin
        n_acc_re  = r_acc_re;
        n_acc_im  = r_acc_im;
        n_all_eq  = r_all_eq;
        n_all_opp = r_all_opp;
        if (i_en && i_valid) begin
            if (i_item.last) begin
                n_acc_re  = '0;
                n_acc_im  = '0;
                n_all_eq  = 1'b1;
                n_all_opp = 1'b1;
            end else begin
                n_acc_re  = acc_re_upd;
                n_acc_im  = acc_im_upd;
                n_all_eq  = eq_upd;
                n_all_opp = opp_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re  <= '0;
            r_acc_im  <= '0;
            r_all_eq  <= 1'b1;
            r_all_opp <= 1'b1;
        end else begin
            r_acc_re  <= n_acc_re;
            r_acc_im  <= n_acc_im;
            r_all_eq  <= n_all_eq;
            r_all_opp <= n_all_opp;
        end
    end

endmodule

>>> sv/complex_dot_product_compare.sv
// Streaming complex dot product with equality, oppositeness and orthogonality
// flags. One element pair (u, v), each part signed Q1.15, is taken per clock;
// the unconjugated sum of u*v is kept in 43-bit saturating accumulators (Q13.30).
// Three register stages (input, products, output) lie between an accepted
// item and its result; a result passes them in that order after its
// last-marked item is accepted. The input keeps taking items while a result
// waits on the output; it stalls only when a second result is ready to leave
// the accumulate stage before the first has been taken.
`timescale 1ns / 1ps

module complex_dot_product_compare (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata from bit 0: u_re[15:0], u_im[15:0], v_re[15:0], v_im[15:0]
    input  logic [cdpc_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata from bit 0: dot_re[42:0], dot_im[42:0], is_equal, is_opposite,
    // is_orthogonal, zero fill to 96 bits
    output logic [cdpc_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);

    localparam int PW = cdpc_pkg::PART_W;

    logic                   en;
    logic                   res_valid;
    cdpc_pkg::t_result      res;

    // input stage
    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic signed [PW-1:0]   r_u_re, r_u_im, r_v_re, r_v_im;

    // product stage
    logic                   r_s2_valid;
    cdpc_pkg::t_prod        r_s2_item, n_s2_item;

    // output register
    logic                   r_out_valid;
    cdpc_pkg::t_result      r_out;

    logic signed [PW:0]     neg_v_re, neg_v_im;

    // the pipeline holds only when a new result meets an unread one
    assign en = !(r_s2_valid && r_s2_item.last && r_out_valid && !i_m_axis_tready);
    assign o_s_axis_tready = en;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_s_axis_tvalid) begin
            r_u_re    <= i_s_axis_tdata[PW-1:0];
            r_u_im    <= i_s_axis_tdata[2*PW-1:PW];
            r_v_re    <= i_s_axis_tdata[3*PW-1:2*PW];
            r_v_im    <= i_s_axis_tdata[4*PW-1:3*PW];
            r_s1_last <= i_s_axis_tlast;
        end
    end

    // products and element compares; negation is taken one bit wider
    assign neg_v_re = (PW+1)'(0) - {r_v_re[PW-1], r_v_re};
    assign neg_v_im = (PW+1)'(0) - {r_v_im[PW-1], r_v_im};

    always_comb begin
        n_s2_item.rr   = r_u_re * r_v_re;
        n_s2_item.ii   = r_u_im * r_v_im;
        n_s2_item.ri   = r_u_re * r_v_im;
        n_s2_item.ir   = r_u_im * r_v_re;
        n_s2_item.eq   = (r_u_re == r_v_re) && (r_u_im == r_v_im);
        n_s2_item.opp  = ({r_u_re[PW-1], r_u_re} == neg_v_re)
                      && ({r_u_im[PW-1], r_u_im} == neg_v_im);
        n_s2_item.last = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid) begin
            r_s2_item <= n_s2_item;
        end
    end

    // accumulate stage
    cdpc_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_s2_valid),
        .i_item      (r_s2_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {
        {(cdpc_pkg::OUT_DATA_W - cdpc_pkg::OUT_BITS){1'b0}},
        r_out.is_orthogonal,
        r_out.is_opposite,
        r_out.is_equal,
        r_out.dot_im,
        r_out.dot_re
    };

endmodule

>>> sv/cdpc_chk.sv
// port-level checker for the complex dot product block, bound to the top level
`timescale 1ns / 1ps

module cdpc_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [cdpc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    localparam int AW = cdpc_pkg::ACC_W;

    logic dot_zero;
    logic f_eq, f_opp, f_orth;

    assign dot_zero = (o_m_axis_tdata[2*AW-1:0] == '0);
    assign f_eq     = o_m_axis_tdata[2*AW];
    assign f_opp    = o_m_axis_tdata[2*AW+1];
    assign f_orth   = o_m_axis_tdata[2*AW+2];

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result withdrawn before it was taken");

    // orthogonality flag agrees with the dot product value
    a_orth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (f_orth == dot_zero))
        else $error("orthogonal flag disagrees with dot product");

    // equal and opposite together means every element was zero
    a_eq_opp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && f_eq && f_opp |-> f_orth)
        else $error("equal and opposite vectors with non-zero dot product");

    // input stalls only behind an unread result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without a waiting result");

    // nothing is offered straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered after reset");

endmodule

bind complex_dot_product_compare cdpc_chk u_cdpc_chk (.*);
